### design/acia_pkg.sv
// ----------------------------------------------------------------------------
// acia_pkg: shared types, constants and frame helpers
// Action codes, register reset values and word-select decoding for the
// asynchronous serial interface.
// ----------------------------------------------------------------------------
package acia_pkg;

    // Input word actions
    typedef enum logic [3:0] {
        ACT_BUS_WRITE = 4'd0,
        ACT_BUS_READ  = 4'd1,
        ACT_TX_CLOCK  = 4'd2,
        ACT_RX_CLOCK  = 4'd3,
        ACT_RX_DATA   = 4'd4,
        ACT_CTS       = 4'd5,
        ACT_DCD       = 4'd6,
        ACT_ERROR     = 4'd7,
        ACT_OVERRUN   = 4'd8
    } action_t;

    // Reset values
    localparam logic [7:0] STATUS_RESET   = 8'h02;
    localparam logic [7:0] IRQ_MASK_RESET = 8'h74;

    // Status bits
    localparam int ST_RDRF = 0;
    localparam int ST_TDRE = 1;
    localparam int ST_DCD  = 2;
    localparam int ST_CTS  = 3;
    localparam int ST_FE   = 4;
    localparam int ST_OVRN = 5;
    localparam int ST_PE   = 6;
    localparam int ST_IRQ  = 7;

    // Transmit control codes in control bits 6..5; master reset code in bits 1..0
    localparam logic [1:0] TX_IRQ_ON  = 2'b01;
    localparam logic [1:0] RTS_HIGH   = 2'b10;
    localparam logic [1:0] MRESET_SEL = 2'b11;

    // Frame buffer limit
    localparam logic [3:0] FRAME_BITS = 4'd12;

    // Word select: 8 data bits
    function automatic logic is_eight(input logic [7:0] cr);
        return cr[4];
    endfunction

    // Word select: parity present (all but 8N2 and 8N1)
    function automatic logic has_parity(input logic [7:0] cr);
        return !(cr[4:2] == 3'b100 || cr[4:2] == 3'b101);
    endfunction

    // Word select: two stop bits (7E2, 7O2, 8N2)
    function automatic logic two_stops(input logic [7:0] cr);
        return (cr[4:2] == 3'b100) || (cr[4:3] == 2'b00);
    endfunction

    // Total frame length in bits
    function automatic logic [3:0] frame_len(input logic [7:0] cr);
        return 4'd9 + {3'b000, is_eight(cr)} + {3'b000, has_parity(cr)}
             + {3'b000, two_stops(cr)};
    endfunction

    // Pick one bit of a frame buffer
    function automatic logic frame_bit(input logic [11:0] f, input logic [3:0] p);
        logic [11:0] s;
        s = f >> p;
        return s[0];
    endfunction

    // Build start, data, parity and stop bits, LSB first
    function automatic logic [11:0] build_frame(input logic [7:0] cr,
                                                input logic [7:0] data);
        logic [7:0]  d;
        logic [11:0] f;
        logic [3:0]  pos;
        d   = is_eight(cr) ? data : {1'b0, data[6:0]};
        f   = {3'b000, d, 1'b0};
        pos = is_eight(cr) ? 4'd9 : 4'd8;
        if (has_parity(cr))
        begin
            if ((^d) ^ cr[2])
                f = f | (12'd1 << pos);
            pos = pos + 4'd1;
        end
        f = f | (12'd1 << pos);
        if (two_stops(cr))
            f = f | (12'd1 << (pos + 4'd1));
        return f;
    endfunction

endpackage

### design/async_serial_acia.sv
// ----------------------------------------------------------------------------
// async_serial_acia: asynchronous serial interface, 6850 style
// Bus access, transmit/receive ticks and line events in, one status word out.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready): one word per bus read or write, tx or
//   rx clock tick, received bit or byte, CTS/DCD level or error event.
//   Output channel (out_valid/out_ready): exactly one result word per input
//   word: read data, emitted tx bit or byte, and IRQ, RTS, DTR and
//   master-reset levels.
//   The result is registered: out_valid rises in the cycle after acceptance.
//   Throughput is one word per cycle while out_ready holds: the whole update
//   is one pass of logic from the register state into the result register.
//   A stalled receiver holds the result register; in_ready stays high while
//   the result register is empty or being taken in the same cycle, so a new
//   word is taken as soon as out_ready returns.
//   Reset clears control, sets status to transmit empty, the interrupt mask
//   to its default and RTS/DTR high. A control write with low bits 11 pulses
//   master_reset in its result; resets all but control, frame_len, mask[1:0].
// ----------------------------------------------------------------------------
module async_serial_acia
    import acia_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] action,
    input  logic       reg_select,
    input  logic [7:0] payload,
    input  logic       bit_mode,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       tx_valid,
    output logic [7:0] tx_value,
    output logic       irq_line,
    output logic       rts_line,
    output logic       dtr_line,
    output logic       master_reset
);

    // State registers
    logic [7:0]  control_reg, control_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  status_prev_reg, status_prev_next;
    logic [7:0]  irq_mask_reg, irq_mask_next;
    logic        dcd_seen_reg, dcd_seen_next;
    logic        dcd_read_reg, dcd_read_next;
    logic        overrun_reg, overrun_next;
    logic [7:0]  rx_data_reg, rx_data_next;
    logic [7:0]  tx_data_reg, tx_data_next;
    logic [11:0] rx_frame_reg, rx_frame_next;
    logic [3:0]  rx_index_reg, rx_index_next;
    logic [11:0] tx_frame_reg, tx_frame_next;
    logic [3:0]  tx_index_reg, tx_index_next;
    logic [3:0]  frame_len_reg, frame_len_next;
    logic        irq_reg, irq_next;
    logic        rts_reg, rts_next;
    logic        dtr_reg, dtr_next;

    // Result registers
    logic        out_valid_reg;
    logic [7:0]  read_data_reg, read_data_next;
    logic        tx_valid_reg, tx_valid_next;
    logic [7:0]  tx_value_reg, tx_value_next;
    logic        mreset_reg, mreset_next;

    // Scratch for the receive decode and the transmit index
    logic [3:0]  rx_pos;
    logic        rx_fin;
    logic [3:0]  tx_idx;

    logic accept;

    // Take a new word whenever the result register is free or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Compute next state and result for one word
    always_comb
    begin
        control_next     = control_reg;
        status_next      = status_reg;
        status_prev_next = status_prev_reg;
        irq_mask_next    = irq_mask_reg;
        dcd_seen_next    = dcd_seen_reg;
        dcd_read_next    = dcd_read_reg;
        overrun_next     = overrun_reg;
        rx_data_next     = rx_data_reg;
        tx_data_next     = tx_data_reg;
        rx_frame_next    = rx_frame_reg;
        rx_index_next    = rx_index_reg;
        tx_frame_next    = tx_frame_reg;
        tx_index_next    = tx_index_reg;
        frame_len_next   = frame_len_reg;
        irq_next         = irq_reg;
        rts_next         = rts_reg;
        dtr_next         = dtr_reg;
        read_data_next   = 8'h00;
        tx_valid_next    = 1'b0;
        tx_value_next    = 8'h00;
        mreset_next      = 1'b0;
        rx_pos           = 4'd0;
        rx_fin           = 1'b0;
        tx_idx           = tx_index_reg;

        case (action)
            ACT_BUS_WRITE:
            begin
                if (reg_select)
                begin
                    // Load transmit data, clear transmit empty
                    tx_data_next = payload;
                    status_next  = status_next & 8'h7D;
                    irq_next     = (status_next & irq_mask_next) != 8'h00;
                    status_next[ST_IRQ] = irq_next;
                end
                else
                begin
                    // Master reset returns everything to reset values first
                    if (payload[1:0] == MRESET_SEL)
                    begin
                        mreset_next      = 1'b1;
                        status_next      = STATUS_RESET;
                        status_prev_next = 8'h00;
                        irq_mask_next    = IRQ_MASK_RESET;
                        dcd_seen_next    = 1'b0;
                        dcd_read_next    = 1'b0;
                        overrun_next     = 1'b0;
                        rx_data_next     = 8'h00;
                        tx_data_next     = 8'h00;
                        rx_frame_next    = 12'h000;
                        rx_index_next    = 4'd0;
                        tx_frame_next    = 12'h000;
                        tx_index_next    = 4'd0;
                        irq_next         = 1'b0;
                        rts_next         = 1'b1;
                        dtr_next         = 1'b1;
                    end
                    frame_len_next   = frame_len(payload);
                    irq_mask_next[1] = payload[6:5] == TX_IRQ_ON;
                    irq_mask_next[0] = payload[7];
                    control_next     = payload;
                end
            end

            ACT_BUS_READ:
            begin
                if (reg_select)
                begin
                    // Read data, drop receive full, overrun and, once status was read, DCD
                    read_data_next = rx_data_reg;
                    rx_data_next   = 8'h00;
                    status_next[ST_RDRF] = 1'b0;
                    if (dcd_read_reg)
                        status_next[ST_DCD] = 1'b0;
                    dcd_read_next = 1'b0;
                    overrun_next  = 1'b0;
                    status_next[ST_OVRN] = 1'b0;
                    irq_next = (status_next & irq_mask_reg) != 8'h00;
                    status_next[ST_IRQ] = irq_next;
                end
                else
                begin
                    read_data_next = status_reg;
                    dcd_read_next  = 1'b1;
                end
            end

            ACT_TX_CLOCK:
            begin
                if (status_prev_reg[ST_TDRE] && !status_reg[ST_TDRE])
                    rts_next = 1'b1;
                status_prev_next = status_reg;
                if (!status_reg[ST_TDRE])
                begin
                    tx_valid_next = 1'b1;
                    if (bit_mode)
                    begin
                        // Shift out the next frame bit, start a frame when idle
                        if ({1'b0, tx_idx} + 5'd1 == {1'b0, frame_len_reg})
                            status_next[ST_TDRE] = 1'b1;
                        if (tx_idx != 4'd0 && tx_idx < frame_len_reg)
                        begin
                            tx_index_next = tx_idx + 4'd1;
                            tx_value_next = {7'd0, frame_bit(tx_frame_reg, tx_idx)};
                        end
                        else
                        begin
                            tx_frame_next = build_frame(control_reg, tx_data_reg);
                            if ({1'b0, tx_idx} + 5'd1 == {1'b0, frame_len_reg})
                                tx_data_next = 8'h00;
                            tx_index_next = 4'd1;
                            tx_value_next = {7'd0, tx_frame_next[0]};
                        end
                    end
                    else
                    begin
                        tx_value_next = tx_data_reg;
                        tx_data_next  = 8'h00;
                        status_next[ST_TDRE] = 1'b1;
                    end
                    if (status_next[ST_TDRE])
                    begin
                        if (control_reg[6:5] == TX_IRQ_ON)
                        begin
                            irq_next = 1'b1;
                            status_next[ST_IRQ] = 1'b1;
                        end
                        rts_next = control_reg[6:5] == RTS_HIGH;
                    end
                    status_prev_next = status_next;
                end
            end

            ACT_RX_CLOCK:
            begin
                if (!status_reg[ST_RDRF])
                    dtr_next = 1'b1;
                status_prev_next = status_reg;
            end

            ACT_RX_DATA:
            begin
                if (status_reg[ST_RDRF])
                begin
                    // Data unread: flag overrun and drop the word
                    status_next[ST_OVRN] = 1'b1;
                    if (control_reg[7] && !overrun_reg)
                    begin
                        irq_next = 1'b1;
                        status_next[ST_IRQ] = 1'b1;
                    end
                    overrun_next = 1'b1;
                end
                else if (bit_mode)
                begin
                    // Assemble a serial frame; idle ones are ignored
                    if (!(rx_index_reg == 4'd0 && payload[0]))
                    begin
                        if (rx_index_reg < FRAME_BITS && payload[0])
                            rx_frame_next = rx_frame_reg | (12'd1 << rx_index_reg);
                        rx_index_next = rx_index_reg + 4'd1;
                        if (rx_index_next >= frame_len_reg)
                        begin
                            // Decode the completed frame
                            status_next = status_next & 8'hAF;
                            rx_data_next = is_eight(control_reg) ? rx_frame_next[8:1]
                                                                 : {1'b0, rx_frame_next[7:1]};
                            rx_pos = is_eight(control_reg) ? 4'd9 : 4'd8;
                            if (has_parity(control_reg))
                            begin
                                if (((^rx_data_next) ^ frame_bit(rx_frame_next, rx_pos))
                                    != control_reg[2])
                                    status_next[ST_PE] = 1'b1;
                                rx_pos = rx_pos + 4'd1;
                            end
                            rx_fin = frame_bit(rx_frame_next, rx_pos);
                            if (!rx_fin)
                                status_next[ST_FE] = 1'b1;
                            rx_pos = rx_pos + 4'd1;
                            if (two_stops(control_reg))
                            begin
                                rx_fin = frame_bit(rx_frame_next, rx_pos);
                                if (!rx_fin)
                                    status_next[ST_FE] = 1'b1;
                            end
                            if ((status_next & 8'h70) == 8'h00)
                                status_next[ST_RDRF] = 1'b1;
                            rx_frame_next = 12'h000;
                            rx_index_next = 4'd0;
                            // Keep a zero stop bit as the next start bit
                            if (status_next[ST_FE] && !rx_fin)
                                rx_index_next = 4'd1;
                        end
                    end
                end
                else
                begin
                    rx_data_next = payload;
                    status_next[ST_RDRF] = 1'b1;
                end
                if (!status_prev_reg[ST_RDRF] && status_next[ST_RDRF])
                begin
                    if (control_reg[7])
                    begin
                        irq_next = 1'b1;
                        status_next[ST_IRQ] = 1'b1;
                    end
                    dtr_next = 1'b0;
                end
                status_prev_next = status_next;
            end

            ACT_CTS:
            begin
                status_next[ST_CTS] = !payload[0];
            end

            ACT_DCD:
            begin
                if (payload[0])
                begin
                    status_next[ST_DCD] = 1'b1;
                    if (control_reg[7] && !dcd_seen_reg)
                    begin
                        irq_next = 1'b1;
                        status_next[ST_IRQ] = 1'b1;
                    end
                    dcd_seen_next = 1'b1;
                    dcd_read_next = 1'b0;
                end
                else
                begin
                    dcd_seen_next = 1'b0;
                end
            end

            ACT_ERROR:
            begin
                status_next = status_next | 8'h78;
            end

            ACT_OVERRUN:
            begin
                status_next[ST_OVRN] = 1'b1;
                if (control_reg[7] && !overrun_reg)
                begin
                    irq_next = 1'b1;
                    status_next[ST_IRQ] = 1'b1;
                end
                overrun_next = 1'b1;
            end

            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    // Advance state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg     <= 8'h00;
            status_reg      <= STATUS_RESET;
            status_prev_reg <= 8'h00;
            irq_mask_reg    <= IRQ_MASK_RESET;
            dcd_seen_reg    <= 1'b0;
            dcd_read_reg    <= 1'b0;
            overrun_reg     <= 1'b0;
            rx_data_reg     <= 8'h00;
            tx_data_reg     <= 8'h00;
            rx_frame_reg    <= 12'h000;
            rx_index_reg    <= 4'd0;
            tx_frame_reg    <= 12'h000;
            tx_index_reg    <= 4'd0;
            frame_len_reg   <= 4'd0;
            irq_reg         <= 1'b0;
            rts_reg         <= 1'b1;
            dtr_reg         <= 1'b1;
        end
        else if (accept)
        begin
            control_reg     <= control_next;
            status_reg      <= status_next;
            status_prev_reg <= status_prev_next;
            irq_mask_reg    <= irq_mask_next;
            dcd_seen_reg    <= dcd_seen_next;
            dcd_read_reg    <= dcd_read_next;
            overrun_reg     <= overrun_next;
            rx_data_reg     <= rx_data_next;
            tx_data_reg     <= tx_data_next;
            rx_frame_reg    <= rx_frame_next;
            rx_index_reg    <= rx_index_next;
            tx_frame_reg    <= tx_frame_next;
            tx_index_reg    <= tx_index_next;
            frame_len_reg   <= frame_len_next;
            irq_reg         <= irq_next;
            rts_reg         <= rts_next;
            dtr_reg         <= dtr_next;
        end
    end

    // Hold result valid until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg <= read_data_next;
            tx_valid_reg  <= tx_valid_next;
            tx_value_reg  <= tx_value_next;
            mreset_reg    <= mreset_next;
        end
    end

    // Result word carries the levels after the update
    logic irq_out_reg, rts_out_reg, dtr_out_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            irq_out_reg <= irq_next;
            rts_out_reg <= rts_next;
            dtr_out_reg <= dtr_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign tx_valid     = tx_valid_reg;
    assign tx_value     = tx_value_reg;
    assign irq_line     = irq_out_reg;
    assign rts_line     = rts_out_reg;
    assign dtr_line     = dtr_out_reg;
    assign master_reset = mreset_reg;

endmodule
